[rtl/idle_gap_frame_buffer_macros.svh]
// Assertion macros used by the idle-gap frame buffer controller (igfb_ctrl).
`ifndef IDLE_GAP_FRAME_BUFFER_MACROS_SVH
`define IDLE_GAP_FRAME_BUFFER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IGFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IGFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/igfb_pkg.sv]
// Shared constants and controller/datapath interface types for the frame buffer.
`timescale 1ns / 1ps

package igfb_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam int DATA_W        = 8;
	localparam int TIMEOUT_W     = 8;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(10);

	// Event kind carried in func
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Commands from controller to datapath
	typedef struct packed {
		logic write_byte;     // store rx_byte, advance write pointer, reload countdown
		logic tick;           // decrement a nonzero countdown
		logic clear_pending;  // frame complete: drop the pending flag
		logic read_issue;     // read the store at the read pointer
		logic advance_rd;     // output word taken: advance read pointer
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic ptr_equal;      // read pointer equals write pointer (nothing to drain)
		logic frame_done;     // a tick now would end a pending frame
	} sts_t;

endpackage

[rtl/igfb_datapath.sv]
// Datapath: byte store, pointers, idle countdown, timeout register and output register.
`timescale 1ns / 1ps

module igfb_datapath #(
	parameter int DEPTH = igfb_pkg::DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  igfb_pkg::cmd_t                  cmd,
	output igfb_pkg::sts_t                  sts,
	input  logic [igfb_pkg::DATA_W-1:0]     rx_byte,
	input  logic                            cfg_write,
	input  logic [igfb_pkg::TIMEOUT_W-1:0]  cfg_data,
	output logic [igfb_pkg::DATA_W-1:0]     out_byte,
	output logic                            out_last
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [igfb_pkg::DATA_W-1:0]    store_q [DEPTH];
	logic [PTR_W-1:0]               wr_ptr_q;
	logic [PTR_W-1:0]               rd_ptr_q;
	logic [igfb_pkg::TIMEOUT_W-1:0] count_q;
	logic [igfb_pkg::TIMEOUT_W-1:0] timeout_q;
	logic                           pending_q;
	logic [igfb_pkg::DATA_W-1:0]    rd_data_s1;
	logic                           last_s1;

	logic [PTR_W-1:0]               wr_ptr_next;
	logic [PTR_W-1:0]               rd_ptr_next;
	logic [igfb_pkg::TIMEOUT_W-1:0] count_dec;

	assign wr_ptr_next = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
	assign rd_ptr_next = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
	assign count_dec   = (count_q != '0) ? count_q - igfb_pkg::TIMEOUT_W'(1) : '0;

	assign sts.ptr_equal  = (rd_ptr_q == wr_ptr_q);
	assign sts.frame_done = pending_q && (count_dec == '0);

	assign out_byte = rd_data_s1;
	assign out_last = last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			count_q   <= '0;
			pending_q <= 1'b0;
			timeout_q <= igfb_pkg::TIMEOUT_RESET;
		end else begin
			if (cfg_write) begin
				timeout_q <= cfg_data;
			end
			if (cmd.write_byte) begin
				wr_ptr_q  <= wr_ptr_next;
				count_q   <= timeout_q;
				pending_q <= 1'b1;
			end
			if (cmd.tick) begin
				count_q <= count_dec;
			end
			if (cmd.clear_pending) begin
				pending_q <= 1'b0;
			end
			if (cmd.advance_rd) begin
				rd_ptr_q <= rd_ptr_next;
			end
		end
	end

	// Store write and registered read; no reset on payload
	always_ff @(posedge clk) begin
		if (cmd.write_byte) begin
			store_q[wr_ptr_q] <= rx_byte;
		end
		if (cmd.read_issue) begin
			rd_data_s1 <= store_q[rd_ptr_q];
			last_s1    <= (rd_ptr_next == wr_ptr_q);
		end
	end

endmodule

[rtl/igfb_ctrl.sv]
// Controller: accepts events and sequences the drain of a completed frame.
`timescale 1ns / 1ps

`include "idle_gap_frame_buffer_macros.svh"

module igfb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           func,
	output logic           out_valid,
	input  logic           out_ready,
	input  logic           out_last,
	input  igfb_pkg::sts_t sts,
	output igfb_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SEND
	} state_t;

	state_t state_q;
	logic   in_acc;
	logic   out_acc;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_SEND);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	always_comb begin
		cmd.write_byte    = in_acc && (func == igfb_pkg::FUNC_BYTE);
		cmd.tick          = in_acc && (func == igfb_pkg::FUNC_TICK);
		cmd.clear_pending = cmd.tick && sts.frame_done;
		cmd.read_issue    = (state_q == ST_READ);
		cmd.advance_rd    = out_acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.clear_pending && !sts.ptr_equal) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (out_ready) begin
						state_q <= out_last ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`IGFB_ASSERT_NOW(a_no_accept_while_draining, clk, arst_n, in_acc, !out_valid, "event accepted during drain")
	`IGFB_ASSERT_NEXT(a_read_then_send, clk, arst_n, state_q == ST_READ, out_valid, "read not followed by output word")
	`IGFB_ASSERT_NEXT(a_last_ends_drain, clk, arst_n, out_acc && out_last, in_ready, "drain continued past last word")
	`IGFB_ASSERT_NEXT(a_done_starts_drain, clk, arst_n, cmd.clear_pending && !sts.ptr_equal, state_q == ST_READ, "completed frame not drained")
	`IGFB_ASSERT_NOW(a_drain_not_empty, clk, arst_n, state_q == ST_READ, !sts.ptr_equal, "drain read with empty store")

endmodule

[rtl/idle_gap_frame_buffer.sv]
// Top level of the idle-gap frame buffer: groups received bytes into frames by idle time.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  in      | in        | in_valid / in_ready  | func, rx_byte
//  out     | out       | out_valid / out_ready| out_byte, last_of_frame
//  cfg     | in        | cfg_valid / cfg_ready| idle_timeout
//
// An event word (byte or tick) is taken whenever no frame is draining.
// A tick that ends a frame starts a drain unless the store is empty; for each word
// ST_READ reads the store, then ST_SEND presents the word until out_ready takes it.
// The input stays closed while a drain runs; the single store read port sets the pace.
// Reset clears pointers, countdown and pending flag and sets the timeout to 10;
// the store itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module idle_gap_frame_buffer #(
	parameter int DEPTH = igfb_pkg::DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Event channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            func,
	input  logic [igfb_pkg::DATA_W-1:0]     rx_byte,
	// Frame output channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [igfb_pkg::DATA_W-1:0]     out_byte,
	output logic                            last_of_frame,
	// Timeout register write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [igfb_pkg::TIMEOUT_W-1:0]  idle_timeout
);

	igfb_pkg::cmd_t cmd;
	igfb_pkg::sts_t sts;
	logic           cfg_write;

	// Register writes are always taken; they must arrive only while idle, which the block does not enforce
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	// Sequence event acceptance and the frame drain
	igfb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_last  (last_of_frame),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold the store, pointers, countdown and the output word
	igfb_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.rx_byte   (rx_byte),
		.cfg_write (cfg_write),
		.cfg_data  (idle_timeout),
		.out_byte  (out_byte),
		.out_last  (last_of_frame)
	);

endmodule
